### rtl/ubdc_pkg.sv
// Shared types, constants and codes for the UART baud divisor calculator.
package ubdc_pkg;

  // Divisor format.
  localparam int INTEGER_BITS  = 16;
  localparam int FRACTION_BITS = 6;
  localparam int GUARD_BITS    = 8;

  // Field widths.
  localparam int CLK_W      = 32;
  localparam int BAUD_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // The divide-by-8 divisor in 1/2^GUARD_BITS units is clock * 2^GUARD_BITS / (8 * baud).
  localparam int PRE_SHIFT = GUARD_BITS - 3;
  localparam int QUO_W     = CLK_W + PRE_SHIFT;
  localparam int RND_SHIFT = GUARD_BITS - FRACTION_BITS;
  localparam int RND_W     = QUO_W + 1 - RND_SHIFT;
  localparam int ERR_W     = RND_SHIFT + 1;
  localparam int DIV_W     = INTEGER_BITS + FRACTION_BITS;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(16000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UART_CLOCK = 1'b0,
    REG_SMART_CARD = 1'b1
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_ZERO  = 2'd2
  } status_e;

  // Word travelling down the divider chain.
  typedef struct packed {
    logic [BAUD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic [BAUD_W-1:0] baud;
  } div_t;

  // Finished result.
  typedef struct packed {
    logic [INTEGER_BITS-1:0]  integer_part;
    logic [FRACTION_BITS-1:0] fraction_part;
    logic                     divide_by_sixteen;
    status_e                  status;
  } res_t;

endpackage

### rtl/ubdc_cell.sv
// One restoring-division cell: develops one quotient bit per word.
module ubdc_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ubdc_pkg::div_t data_i,
  input  logic          dividend_bit_i,
  output logic          valid_o,
  input  logic          ready_i,
  output ubdc_pkg::div_t data_o
);

  logic           valid_q, valid_d;
  ubdc_pkg::div_t data_q, data_d;
  logic [ubdc_pkg::BAUD_W:0] rem_shift;
  logic [ubdc_pkg::BAUD_W:0] rem_diff;
  logic                      take;

  // A word may enter when this cell is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rem_shift = {data_i.rem, dividend_bit_i};
    rem_diff  = rem_shift - {1'b0, data_i.baud};
    take      = (rem_shift >= {1'b0, data_i.baud});
    data_d.baud = data_i.baud;
    data_d.quo  = {data_i.quo[ubdc_pkg::QUO_W-2:0], take};
    data_d.rem  = take ? rem_diff[ubdc_pkg::BAUD_W-1:0] : rem_shift[ubdc_pkg::BAUD_W-1:0];
    valid_d     = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/ubdc_round.sv
// Output stage: rounds both divisors, picks the oversampling mode and holds the result.
module ubdc_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ubdc_pkg::div_t data_i,
  input  logic           smart_card_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ubdc_pkg::res_t res_o
);

  localparam logic [ubdc_pkg::QUO_W-1:0] RES_MASK =
    ubdc_pkg::QUO_W'((64'd1 << ubdc_pkg::RND_SHIFT) - 64'd1);
  localparam logic [ubdc_pkg::ERR_W-1:0] UNIT =
    ubdc_pkg::ERR_W'(64'd1 << ubdc_pkg::RND_SHIFT);
  localparam logic [ubdc_pkg::QUO_W:0] HALF =
    (ubdc_pkg::QUO_W + 1)'((64'd1 << ubdc_pkg::RND_SHIFT) >> 1);

  logic           valid_q, valid_d;
  ubdc_pkg::res_t res_q, res_d;

  logic [ubdc_pkg::QUO_W-1:0] q8, q16;
  logic [ubdc_pkg::ERR_W-1:0] r8, r16, d8, d16, e8, e16;
  logic [ubdc_pkg::QUO_W:0]   sum8, sum16;
  logic [ubdc_pkg::RND_W-1:0] rnd8, rnd16, chosen;
  logic                       ovf8, ovf_chosen, use16;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    q8  = data_i.quo;
    q16 = {1'b0, data_i.quo[ubdc_pkg::QUO_W-1:1]};

    // Distance of the exact value from the nearest rounding step.
    r8  = ubdc_pkg::ERR_W'(q8 & RES_MASK);
    r16 = ubdc_pkg::ERR_W'(q16 & RES_MASK);
    d8  = UNIT - r8;
    d16 = UNIT - r16;
    e8  = (r8 == '0) ? '0 : ((r8 < d8) ? r8 : d8);
    e16 = (r16 == '0) ? '0 : ((r16 < d16) ? r16 : d16);

    sum8  = {1'b0, q8} + HALF;
    sum16 = {1'b0, q16} + HALF;
    rnd8  = ubdc_pkg::RND_W'(sum8 >> ubdc_pkg::RND_SHIFT);
    rnd16 = ubdc_pkg::RND_W'(sum16 >> ubdc_pkg::RND_SHIFT);

    ovf8       = (rnd8 >> ubdc_pkg::DIV_W) != '0;
    use16      = smart_card_i || ovf8 || (e16 < e8);
    chosen     = use16 ? rnd16 : rnd8;
    ovf_chosen = (chosen >> ubdc_pkg::DIV_W) != '0;

    res_d.integer_part      = '0;
    res_d.fraction_part     = '0;
    res_d.divide_by_sixteen = 1'b0;
    res_d.status            = ubdc_pkg::STATUS_OK;
    if (data_i.baud == '0) begin
      res_d.status = ubdc_pkg::STATUS_ZERO;
    end else if (ovf_chosen) begin
      res_d.status = ubdc_pkg::STATUS_RANGE;
    end else begin
      res_d.integer_part =
        chosen[ubdc_pkg::DIV_W-1:ubdc_pkg::FRACTION_BITS];
      res_d.fraction_part     = chosen[ubdc_pkg::FRACTION_BITS-1:0];
      res_d.divide_by_sixteen = use16;
    end

    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/uart_baud_divisor_calc_core.sv
// UART fractional baud divisor calculator: divider cell chain plus rounding stage.
//
// Each baud rate word yields one divisor word: a 16-bit integer part, a 6-bit
// fraction in 64ths and the 8x/16x oversampling choice, or an error status.
// One word enters per clock unless the output stalls; each word passes a chain
// of 37 restoring-division cells, one quotient bit per cell, followed by the
// registered rounding and mode-select stage. Each stage holds its word until the
// next stage is free, so gaps in the flow are squeezed out while the output is
// stalled. The UART clock register resets to 16000000 and smart-card mode to off;
// write them only while no word is in flight.
module uart_baud_divisor_calc_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ubdc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ubdc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ubdc_pkg::BAUD_W-1:0]         baud_rate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ubdc_pkg::INTEGER_BITS-1:0]   integer_part_o,
  output logic [ubdc_pkg::FRACTION_BITS-1:0]  fraction_part_o,
  output logic                                divide_by_sixteen_o,
  output logic [ubdc_pkg::STATUS_W-1:0]       status_o
);

  logic [ubdc_pkg::CLK_W-1:0] clock_q, clock_d;
  logic                       smart_card_q, smart_card_d;

  logic [ubdc_pkg::QUO_W-1:0] dividend;
  logic                       valid [0:ubdc_pkg::QUO_W];
  logic                       ready [0:ubdc_pkg::QUO_W];
  ubdc_pkg::div_t             data  [0:ubdc_pkg::QUO_W];
  ubdc_pkg::res_t             res;

  always_comb begin
    clock_d      = clock_q;
    smart_card_d = smart_card_q;
    if (cfg_we_i) begin
      case (ubdc_pkg::cfg_idx_e'(cfg_idx_i))
        ubdc_pkg::REG_UART_CLOCK: clock_d = cfg_wdata_i[ubdc_pkg::CLK_W-1:0];
        ubdc_pkg::REG_SMART_CARD: smart_card_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q      <= ubdc_pkg::CLK_RESET;
      smart_card_q <= 1'b0;
    end else begin
      clock_q      <= clock_d;
      smart_card_q <= smart_card_d;
    end
  end

  // The user must keep the clock stable while words are in flight (the block does
  // not enforce this), so each cell reads its dividend bit straight from the register.
  assign dividend = {clock_q, {ubdc_pkg::PRE_SHIFT{1'b0}}};

  assign valid[0]     = in_valid_i;
  assign in_ready_o   = ready[0];
  assign data[0].rem  = '0;
  assign data[0].quo  = '0;
  assign data[0].baud = baud_rate_i;

  for (genvar k = 0; k < ubdc_pkg::QUO_W; k++) begin : g_cell
    ubdc_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .valid_i        (valid[k]),
      .ready_o        (ready[k]),
      .data_i         (data[k]),
      .dividend_bit_i (dividend[ubdc_pkg::QUO_W-1-k]),
      .valid_o        (valid[k+1]),
      .ready_i        (ready[k+1]),
      .data_o         (data[k+1])
    );
  end

  ubdc_round u_round (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid[ubdc_pkg::QUO_W]),
    .ready_o      (ready[ubdc_pkg::QUO_W]),
    .data_i       (data[ubdc_pkg::QUO_W]),
    .smart_card_i (smart_card_q),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .res_o        (res)
  );

  assign integer_part_o      = res.integer_part;
  assign fraction_part_o     = res.fraction_part;
  assign divide_by_sixteen_o = res.divide_by_sixteen;
  assign status_o            = res.status;

  // An error word carries an all-zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ubdc_pkg::STATUS_OK) |->
      (integer_part_o == '0) && (fraction_part_o == '0) && !divide_by_sixteen_o)
    else $error("error word with nonzero divisor");

  // Only the three defined status codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ubdc_pkg::STATUS_OK) ||
      (status_o == ubdc_pkg::STATUS_RANGE) || (status_o == ubdc_pkg::STATUS_ZERO))
    else $error("undefined status code");

  // Smart-card mode always yields 16x oversampling on a good word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && smart_card_q && (status_o == ubdc_pkg::STATUS_OK) |->
      divide_by_sixteen_o)
    else $error("smart-card mode without 16x oversampling");

  // A stalled chain end must back-pressure the last divider cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !ready[ubdc_pkg::QUO_W])
    else $error("rounding stage accepts while holding a stalled word");

endmodule
